### src/hsbk_pkg.sv
// ============================================================================
// hsbk_pkg
// Shared sizes, entry layout and control structs of the hash sum-by-key table.
// ============================================================================
package hsbk_pkg;

    // Table geometry; TABLE_SLOTS is a power of two, so a key's home slot is
    // its low SLOT_BITS bits.
    localparam int TABLE_SLOTS    = 1024;
    localparam int MAX_PROBES     = 8;
    localparam int ID_BITS        = 20;
    localparam int SLOT_BITS      = $clog2(TABLE_SLOTS);
    localparam int PROBE_LIMIT    = (MAX_PROBES < TABLE_SLOTS) ? MAX_PROBES : TABLE_SLOTS;
    localparam int PROBE_CNT_BITS = $clog2(PROBE_LIMIT + 1);

    localparam int KEY_BITS       = 64;
    localparam int SUM_BITS       = 32;
    localparam int REP_BITS       = 20;
    localparam int SLOT_PORT_BITS = 10;

    typedef logic [SLOT_BITS-1:0] slot_idx_t;

    // One table entry as it sits in the memory.
    typedef struct packed {
        logic                       occ;
        logic [KEY_BITS-1:0]        key;
        logic [ID_BITS-1:0]         id;
        logic signed [SUM_BITS-1:0] sum;
    } entry_t;

    // Outcome of the probe walk, handed to the result stage.
    typedef struct packed {
        logic                       readout;
        logic                       hit;
        logic                       have_free;
        slot_idx_t                  sel_slot;
        slot_idx_t                  free_slot;
        entry_t                     sel_entry;
        logic [KEY_BITS-1:0]        key;
        logic [ID_BITS-1:0]         id;
        logic signed [SUM_BITS-1:0] amount;
    } probe_t;

    // Result word fields.
    typedef struct packed {
        logic                       found;
        logic                       table_full;
        logic [REP_BITS-1:0]        representative_id;
        logic                       slot_valid;
        logic [KEY_BITS-1:0]        slot_key;
        logic signed [SUM_BITS-1:0] slot_sum;
    } result_t;

    // Write-back request to the entry memory.
    typedef struct packed {
        logic      we;
        slot_idx_t addr;
        entry_t    data;
    } wr_t;

    function automatic slot_idx_t slot_index(input logic [SLOT_PORT_BITS-1:0] s);
        logic [31:0] w;
        w = 32'(s);
        return w[SLOT_BITS-1:0];
    endfunction

    function automatic logic [ID_BITS-1:0] id_trim(input logic [REP_BITS-1:0] id);
        logic [31:0] w;
        w = 32'(id);
        return w[ID_BITS-1:0];
    endfunction

    function automatic logic [REP_BITS-1:0] rep_of(input logic [ID_BITS-1:0] id);
        logic [31:0] w;
        w = 32'(id);
        return w[REP_BITS-1:0];
    endfunction

endpackage

### src/hsbk_ram.sv
// ============================================================================
// hsbk_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module hsbk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/hsbk_result.sv
// ============================================================================
// hsbk_result
// Build the result word and the write-back entry from the probe outcome.
// ============================================================================
module hsbk_result (
    input  hsbk_pkg::probe_t  probe,
    output hsbk_pkg::result_t res,
    output hsbk_pkg::wr_t     wr
);

    function automatic logic signed [hsbk_pkg::SUM_BITS-1:0] sat_add(
        input logic signed [hsbk_pkg::SUM_BITS-1:0] a,
        input logic signed [hsbk_pkg::SUM_BITS-1:0] b
    );
        logic [hsbk_pkg::SUM_BITS:0] s;
        s = {a[hsbk_pkg::SUM_BITS-1], a} + {b[hsbk_pkg::SUM_BITS-1], b};
        if (s[hsbk_pkg::SUM_BITS] != s[hsbk_pkg::SUM_BITS-1])
        begin
            // Clamp toward the sign of the exact sum.
            return s[hsbk_pkg::SUM_BITS] ? {1'b1, {(hsbk_pkg::SUM_BITS-1){1'b0}}}
                                         : {1'b0, {(hsbk_pkg::SUM_BITS-1){1'b1}}};
        end
        return s[hsbk_pkg::SUM_BITS-1:0];
    endfunction

    logic signed [hsbk_pkg::SUM_BITS-1:0] acc_sum;

    assign acc_sum = sat_add(probe.sel_entry.sum, probe.amount);

    always_comb
    begin
        res      = '0;
        wr       = '0;
        priority if (probe.readout)
        begin
            // Return the slot if it holds an entry, then mark it free.
            if (probe.sel_entry.occ)
            begin
                res.representative_id = hsbk_pkg::rep_of(probe.sel_entry.id);
                res.slot_valid        = 1'b1;
                res.slot_key          = probe.sel_entry.key;
                res.slot_sum          = probe.sel_entry.sum;
            end
            wr.we   = 1'b1;
            wr.addr = probe.sel_slot;
        end
        else if (probe.hit)
        begin
            res.found             = 1'b1;
            res.representative_id = hsbk_pkg::rep_of(probe.sel_entry.id);
            res.slot_sum          = acc_sum;
            wr.we                 = 1'b1;
            wr.addr               = probe.sel_slot;
            wr.data.occ           = 1'b1;
            wr.data.key           = probe.sel_entry.key;
            wr.data.id            = probe.sel_entry.id;
            wr.data.sum           = acc_sum;
        end
        else if (probe.have_free)
        begin
            res.representative_id = hsbk_pkg::rep_of(probe.id);
            res.slot_sum          = probe.amount;
            wr.we                 = 1'b1;
            wr.addr               = probe.free_slot;
            wr.data.occ           = 1'b1;
            wr.data.key           = probe.key;
            wr.data.id            = probe.id;
            wr.data.sum           = probe.amount;
        end
        else
        begin
            // No room in the window: drop the item.
            res.table_full = 1'b1;
        end
    end

endmodule

### src/hash_sum_by_key_table_core.sv
// ============================================================================
// hash_sum_by_key_table_core
// Hash aggregation table: sums amounts per 64-bit key with bounded probing.
// ============================================================================
// Flow, accept to result registered: S_IDLE takes the word and issues the first read;
//   S_PROBE reads the addressed slot for a read-out, or walks the window to a match
//   or to its end for a new key or full table; S_WRITE registers result and write-back.
// Input: one word at a time in the probe walk (entry RAM read port); the next word can
//   be taken in the cycle after the result is registered.
// Reset: a clearing pass writes every entry free, with in_stall held high throughout.
// ============================================================================
module hash_sum_by_key_table_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 mode,
    input  logic [hsbk_pkg::KEY_BITS-1:0]        key,
    input  logic [hsbk_pkg::REP_BITS-1:0]        item_id,
    input  logic signed [hsbk_pkg::SUM_BITS-1:0] amount,
    input  logic [hsbk_pkg::SLOT_PORT_BITS-1:0]  slot,
    // Output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 found,
    output logic                                 table_full,
    output logic [hsbk_pkg::REP_BITS-1:0]        representative_id,
    output logic                                 slot_valid,
    output logic [hsbk_pkg::KEY_BITS-1:0]        slot_key,
    output logic signed [hsbk_pkg::SUM_BITS-1:0] slot_sum
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE,
        S_WRITE
    } state_t;

    state_t                                   state_reg;
    hsbk_pkg::slot_idx_t                      clr_cnt_reg;
    logic [hsbk_pkg::PROBE_CNT_BITS-1:0]      probe_cnt_reg;
    hsbk_pkg::slot_idx_t                      home_reg;
    hsbk_pkg::probe_t                         probe_reg;
    hsbk_pkg::result_t                        res_reg;
    logic                                     out_valid_reg;

    hsbk_pkg::entry_t                         rd_entry;
    hsbk_pkg::slot_idx_t                      cur_idx;
    hsbk_pkg::slot_idx_t                      start_idx;
    hsbk_pkg::slot_idx_t                      raddr;
    hsbk_pkg::result_t                        res_next;
    hsbk_pkg::wr_t                            wr_res;
    hsbk_pkg::wr_t                            wr_ram;
    logic                                     in_take;
    logic                                     out_free;
    logic                                     key_match;
    logic                                     last_probe;

    assign in_take    = in_valid && (state_reg == S_IDLE);
    assign out_free   = !out_valid_reg || !out_stall;
    assign cur_idx    = home_reg + hsbk_pkg::SLOT_BITS'(probe_cnt_reg);
    assign key_match  = rd_entry.occ && (rd_entry.key == probe_reg.key);
    assign last_probe = (probe_cnt_reg == hsbk_pkg::PROBE_CNT_BITS'(hsbk_pkg::PROBE_LIMIT - 1));

    // Home slot of the key, or the addressed slot for a read-out.
    assign start_idx = mode ? hsbk_pkg::slot_index(slot) : key[hsbk_pkg::SLOT_BITS-1:0];

    // Issue the first read on accept, then the next slot of the window each
    // probe cycle; the extra read past the window end is harmless.
    assign raddr = (state_reg == S_PROBE) ? cur_idx + hsbk_pkg::SLOT_BITS'(1) : start_idx;

    hsbk_result u_result (
        .probe (probe_reg),
        .res   (res_next),
        .wr    (wr_res)
    );

    // Clearing pass owns the write port after reset; afterward the write-back
    // lands only in the cycle the result is registered.
    always_comb
    begin
        wr_ram = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_ram.we   = 1'b1;
                wr_ram.addr = clr_cnt_reg;
            end
            S_WRITE:
            begin
                wr_ram    = wr_res;
                wr_ram.we = wr_res.we && out_free;
            end
            default:
            begin
                wr_ram = '0;
            end
        endcase
    end

    hsbk_ram #(
        .WIDTH ($bits(hsbk_pkg::entry_t)),
        .DEPTH (hsbk_pkg::TABLE_SLOTS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (wr_ram.we),
        .waddr (wr_ram.addr),
        .wdata (wr_ram.data),
        .raddr (raddr),
        .rdata (rd_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            probe_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            probe_reg     <= '0;
            home_reg      <= '0;
            res_reg       <= '0;
        end
        else
        begin
            // Drop the result word once the sink takes it; a write-back cycle
            // loads the next word itself.
            if (out_valid_reg && !out_stall && (state_reg != S_WRITE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + hsbk_pkg::SLOT_BITS'(1);
                    if (clr_cnt_reg == hsbk_pkg::SLOT_BITS'(hsbk_pkg::TABLE_SLOTS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        home_reg            <= start_idx;
                        probe_cnt_reg       <= '0;
                        probe_reg.readout   <= mode;
                        probe_reg.hit       <= 1'b0;
                        probe_reg.have_free <= 1'b0;
                        probe_reg.key       <= key;
                        probe_reg.id        <= hsbk_pkg::id_trim(item_id);
                        probe_reg.amount    <= amount;
                        state_reg           <= S_PROBE;
                    end
                end
                S_PROBE:
                begin
                    priority if (probe_reg.readout)
                    begin
                        probe_reg.sel_entry <= rd_entry;
                        probe_reg.sel_slot  <= home_reg;
                        state_reg           <= S_WRITE;
                    end
                    else if (key_match)
                    begin
                        // Stop at the matching entry; hold its contents.
                        probe_reg.hit       <= 1'b1;
                        probe_reg.sel_entry <= rd_entry;
                        probe_reg.sel_slot  <= cur_idx;
                        state_reg           <= S_WRITE;
                    end
                    else
                    begin
                        // Remember the first free slot but keep walking: a
                        // matching key may sit behind it.
                        if (!rd_entry.occ && !probe_reg.have_free)
                        begin
                            probe_reg.have_free <= 1'b1;
                            probe_reg.free_slot <= cur_idx;
                        end
                        probe_cnt_reg <= probe_cnt_reg + hsbk_pkg::PROBE_CNT_BITS'(1);
                        if (last_probe)
                        begin
                            state_reg <= S_WRITE;
                        end
                    end
                end
                S_WRITE:
                begin
                    // Hold here until the output register is free.
                    if (out_free)
                    begin
                        res_reg       <= res_next;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall          = (state_reg != S_IDLE);
    assign out_valid         = out_valid_reg;
    assign found             = res_reg.found;
    assign table_full        = res_reg.table_full;
    assign representative_id = res_reg.representative_id;
    assign slot_valid        = res_reg.slot_valid;
    assign slot_key          = res_reg.slot_key;
    assign slot_sum          = res_reg.slot_sum;

endmodule

### src/hsbk_checker.sv
// ============================================================================
// hsbk_checker
// Port-level checks of the hash sum-by-key table, bound to the top level.
// ============================================================================
module hsbk_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic                                 found,
    input logic                                 table_full,
    input logic [hsbk_pkg::REP_BITS-1:0]        representative_id,
    input logic                                 slot_valid,
    input logic [hsbk_pkg::KEY_BITS-1:0]        slot_key,
    input logic signed [hsbk_pkg::SUM_BITS-1:0] slot_sum
);

    // One word at a time: an accepted word closes the input at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken on back-to-back cycles");

    // A stalled result word stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word withdrawn while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && slot_valid |-> !found && !table_full)
        else $error("read-out result carries insert status");

    // A dropped item reports nothing else.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_full |-> !found && representative_id == '0 && slot_sum == '0)
        else $error("full-table result not cleared");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !slot_valid |-> slot_key == '0)
        else $error("slot key shown without a valid slot");

endmodule

bind hash_sum_by_key_table_core hsbk_checker u_hsbk_checker (.*);
